// ===== rtl/e2g_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the ECEF to geodetic unit.
// No dependencies; e2g_cordic and ecef_to_geodetic_unit import this package.
`timescale 1ns / 1ps
package e2g_pkg;

    localparam int LENGTH_BITS  = 40;
    localparam int ANGLE_BITS   = 32;
    localparam int FRAC         = 60 - LENGTH_BITS;
    localparam int ANG_SH       = 62 - ANGLE_BITS;
    localparam int CORDIC_ITERS = 60;
    localparam int ITER_W       = 6;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 48;

    localparam logic signed [63:0] HALF_TURN = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] QTR_TURN  = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] LMAX      = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ONE_Q62_S = 64'sh4000_0000_0000_0000;
    localparam logic [63:0]        ONE_Q62   = 64'h4000_0000_0000_0000;
    localparam logic [63:0]        PI_Q60    = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0]        COS_FLOOR = 64'd461168602;
    localparam logic [35:0]        A_RESET   = 36'd6378137000;
    localparam logic [47:0]        E2_RESET  = 48'd1884300451817;

    localparam logic signed [63:0] ANG_MAX64 = (64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] ANG_MIN64 = -(64'sd1 <<< (ANGLE_BITS - 1));
    localparam logic signed [63:0] LEN_MAX64 = (64'sd1 <<< (LENGTH_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] LEN_MIN64 = -(64'sd1 <<< (LENGTH_BITS - 1));

    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_SQ     = 1'b1;

    typedef enum logic {CORDIC_VEC, CORDIC_ROT} cordic_mode_t;

    typedef struct packed {
        logic signed [LENGTH_BITS-1:0] ecef_x;
        logic signed [LENGTH_BITS-1:0] ecef_y;
        logic signed [LENGTH_BITS-1:0] ecef_z;
    } ecef_in_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0]  longitude;
        logic signed [ANGLE_BITS-1:0]  latitude;
        logic signed [LENGTH_BITS-1:0] height_mm;
    } geo_out_t;

    typedef logic [63:0] atan_tab_t [CORDIC_ITERS];

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] cap_lmax(input logic [127:0] v);
        return (v > 128'(LMAX)) ? 64'(LMAX) : v[63:0];
    endfunction

    function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = 65'(a) + 65'(b);
        if (sum > 65'(LMAX)) return LMAX;
        else if (sum < -65'(LMAX)) return -LMAX;
        else return sum[63:0];
    endfunction

    function automatic logic [ANGLE_BITS-1:0] angle_out(input logic signed [63:0] ang);
        logic signed [63:0] v;
        v = (ang + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
        if (v > ANG_MAX64) v = ANG_MAX64;
        else if (v < ANG_MIN64) v = ANG_MIN64;
        return v[ANGLE_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] length_out(input logic signed [63:0] h);
        logic signed [63:0] v;
        v = (h + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (v > LEN_MAX64) v = LEN_MAX64;
        else if (v < LEN_MIN64) v = LEN_MIN64;
        return v[LENGTH_BITS-1:0];
    endfunction

    // Elaboration-time helpers: long division and square root by bit loops.
    function automatic logic [127:0] udiv_const(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] q;
        logic [64:0]  rem;
        q   = '0;
        rem = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt_const(input logic [127:0] n);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [63:0] root;
        rem  = '0;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            rem   = {rem[65:0], n[2*i+1], n[2*i]};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t    tab;
        logic [63:0]  r;
        logic [63:0]  term;
        logic [127:0] num;
        int           odd;
        int           sh;
        tab[0] = 64'h0800_0000_0000_0000;
        for (int i = 1; i < CORDIC_ITERS; i++) begin
            r = '0;
            for (int k = 0; k < 32; k++) begin
                odd = 2 * k + 1;
                sh  = i * odd;
                if (sh <= 62) begin
                    num  = udiv_const(128'(ONE_Q62 >> sh), 64'(odd));
                    term = num[63:0];
                    if ((k & 1) == 1) r = r - term;
                    else r = r + term;
                end
            end
            num    = udiv_const(({64'b0, r} << 59) + 128'(PI_Q60 >> 1), PI_Q60);
            tab[i] = num[63:0];
        end
        return tab;
    endfunction

    function automatic logic [63:0] build_inv_gain();
        logic [63:0]  c;
        logic [127:0] q;
        c = ONE_Q62;
        for (int i = 0; i <= 31; i++) begin
            q = udiv_const({64'b0, c} << (2 * i), (64'd1 << (2 * i)) + 64'd1);
            c = q[63:0];
        end
        q = {64'b0, c} << 62;
        return isqrt_const(q);
    endfunction

    localparam atan_tab_t   ATAN_TAB = build_atan_tab();
    localparam logic [63:0] INV_GAIN = build_inv_gain();

endpackage

// ===== rtl/e2g_mul.sv =====
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier over four partial products.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module e2g_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] product
);
    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [6:0]   off_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp_next;
    logic [6:0]   off_next;

    always_comb begin
        a_half   = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half   = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_next  = {32'b0, a_half} * {32'b0, b_half};
        off_next = (7'(cnt_reg[1]) + 7'(cnt_reg[0])) << 5;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= op_a;
                b_reg    <= op_b;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg < 3'd4) begin
                    pp_reg  <= pp_next;
                    off_reg <= off_next;
                end
                // accumulate the partial product registered on the previous cycle
                if (cnt_reg != 3'd0) begin
                    acc_reg <= acc_reg + ({64'b0, pp_reg} << off_reg);
                end
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/e2g_div.sv =====
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module e2g_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] dividend,
    input  logic [63:0]  divisor,
    output logic         done,
    output logic [127:0] quotient
);
    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] nq_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  d_reg;
    logic [64:0]  rem_sh;
    logic [64:0]  rem_sub;
    logic         ge;

    always_comb begin
        rem_sh  = {rem_reg, nq_reg[127]};
        rem_sub = rem_sh - {1'b0, d_reg};
        ge      = rem_sh >= {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                nq_reg   <= dividend;
                rem_reg  <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                // dividend bits leave at the top, quotient bits enter at the bottom
                nq_reg  <= {nq_reg[126:0], ge};
                rem_reg <= ge ? rem_sub[63:0] : rem_sh[63:0];
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = nq_reg;

endmodule

// ===== rtl/e2g_sqrt.sv =====
// Integer square root of a 128-bit value, one result bit per cycle (digit by digit).
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module e2g_sqrt (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] radicand,
    output logic         done,
    output logic [63:0]  root
);
    logic         busy_reg;
    logic         done_reg;
    logic [5:0]   cnt_reg;
    logic [127:0] n_reg;
    logic [65:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic [67:0]  rem_sub;
    logic         fits;

    always_comb begin
        rem_sh  = {rem_reg, n_reg[127:126]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_sh - trial;
        fits    = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                n_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                n_reg    <= {n_reg[125:0], 2'b00};
                rem_reg  <= fits ? rem_sub[65:0] : rem_sh[65:0];
                root_reg <= {root_reg[62:0], fits};
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/e2g_cordic.sv =====
// Shared shift-add CORDIC: vectoring (atan2 with range fold and normalization) and rotation.
// Depends on e2g_pkg for the arctangent table, inverse gain and angle constants.
`timescale 1ns / 1ps
module e2g_cordic (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  e2g_pkg::cordic_mode_t      mode,
    input  logic signed [63:0]         x_in,
    input  logic signed [63:0]         y_in,
    input  logic signed [63:0]         z_in,
    output logic                       done,
    output logic signed [63:0]         x_out,
    output logic signed [63:0]         y_out,
    output logic signed [63:0]         z_out
);
    import e2g_pkg::*;

    typedef enum logic [1:0] {CD_IDLE, CD_NORM, CD_ITER} cd_state_t;

    cd_state_t          state_reg;
    cordic_mode_t       mode_reg;
    logic               done_reg;
    logic [ITER_W-1:0]  i_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [63:0] z_reg;
    logic signed [63:0] base_reg;
    logic [63:0]        m_reg;

    logic signed [63:0] x0;
    logic signed [63:0] y0;
    logic signed [63:0] base0;
    logic [63:0]        m0;
    logic signed [63:0] z_clamp;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] tab;
    logic               sub_x;

    always_comb begin
        x0    = x_in[63] ? -x_in : x_in;
        y0    = x_in[63] ? -y_in : y_in;
        base0 = x_in[63] ? (y_in[63] ? -HALF_TURN : HALF_TURN) : 64'sd0;
        m0    = (mag64(x0) > mag64(y0)) ? mag64(x0) : mag64(y0);
        if (z_in > QTR_TURN) z_clamp = QTR_TURN;
        else if (z_in < -QTR_TURN) z_clamp = -QTR_TURN;
        else z_clamp = z_in;
        dx    = y_reg >>> i_reg;
        dy    = x_reg >>> i_reg;
        tab   = $signed(ATAN_TAB[i_reg]);
        sub_x = (mode_reg == CORDIC_VEC) ? !(y_reg > 64'sd0) : !z_reg[63];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                CD_IDLE: begin
                    if (start) begin
                        mode_reg <= mode;
                        i_reg    <= '0;
                        if (mode == CORDIC_ROT) begin
                            x_reg     <= $signed(INV_GAIN);
                            y_reg     <= 64'sd0;
                            z_reg     <= z_clamp;
                            base_reg  <= 64'sd0;
                            state_reg <= CD_ITER;
                        end else if (x_in == 64'sd0 && y_in == 64'sd0) begin
                            z_reg    <= 64'sd0;
                            base_reg <= 64'sd0;
                            done_reg <= 1'b1;
                        end else begin
                            x_reg     <= x0;
                            y_reg     <= y0;
                            z_reg     <= 64'sd0;
                            base_reg  <= base0;
                            m_reg     <= m0;
                            state_reg <= CD_NORM;
                        end
                    end
                end
                CD_NORM: begin
                    // bring the larger magnitude into [2^59, 2^60)
                    if (m_reg[63:60] != 4'd0) begin
                        x_reg <= x_reg >>> 1;
                        y_reg <= y_reg >>> 1;
                        m_reg <= m_reg >> 1;
                    end else if (!m_reg[59]) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                        m_reg <= m_reg << 1;
                    end else begin
                        state_reg <= CD_ITER;
                    end
                end
                CD_ITER: begin
                    if (sub_x) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - tab;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + tab;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= CD_IDLE;
                    end
                end
                default: state_reg <= CD_IDLE;
            endcase
        end
    end

    always_comb begin
        if (x_reg > ONE_Q62_S) x_out = ONE_Q62_S;
        else if (x_reg < -ONE_Q62_S) x_out = -ONE_Q62_S;
        else x_out = x_reg;
        if (y_reg > ONE_Q62_S) y_out = ONE_Q62_S;
        else if (y_reg < -ONE_Q62_S) y_out = -ONE_Q62_S;
        else y_out = y_reg;
        z_out = base_reg + z_reg;
    end

    assign done = done_reg;

endmodule

// ===== rtl/ecef_to_geodetic_unit.sv =====
// ECEF to geodetic conversion (Bowring refinement); top level with sequencer and shared units.
// Time to result is set mainly by the divider and the 60-step CORDIC, which runs twice
// (rotation, vectoring) per refinement step; each vectoring CORDIC pass also normalizes
// its input first, and the near-pole height path uses a square root and a multiply in place
// of the height division.
// Throughput: one item at a time; s_ready is high only while the sequencer is idle,
// and a finished result waits in the output register while the next beat is taken.
// Reset (aresetn, synchronous, active low) clears control state and loads WGS84 defaults.
`timescale 1ns / 1ps
module ecef_to_geodetic_unit #(
    parameter int REFINE_STEPS = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  e2g_pkg::ecef_in_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output e2g_pkg::geo_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [e2g_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [e2g_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import e2g_pkg::*;

    localparam int K_W = $clog2(REFINE_STEPS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_ROOT_P, ST_LON, ST_PP, ST_LAT0, ST_ROT,
        ST_SIN2, ST_E2S2, ST_ROOT_W, ST_NPV, ST_T1, ST_TERM, ST_LATK, ST_HDIV,
        ST_ROOT_B, ST_POLAR, ST_OUT
    } seq_state_t;

    seq_state_t         state_reg;
    logic [K_W-1:0]     k_reg;
    logic [35:0]        a_reg;
    logic [47:0]        e2_reg;
    logic signed [63:0] x_reg;
    logic signed [63:0] y_reg;
    logic signed [63:0] z_reg;
    logic [63:0]        p_reg;
    logic signed [63:0] lon_reg;
    logic signed [63:0] lat_reg;
    logic signed [63:0] c_reg;
    logic signed [63:0] s_reg;
    logic [63:0]        n_reg;
    logic [127:0]       acc_reg;
    logic signed [63:0] h_reg;
    logic               m_valid_reg;
    geo_out_t           m_data_reg;

    logic               mul_start_reg;
    logic [63:0]        mul_a_reg;
    logic [63:0]        mul_b_reg;
    logic               div_start_reg;
    logic [127:0]       div_n_reg;
    logic [63:0]        div_d_reg;
    logic               sqrt_start_reg;
    logic [127:0]       sqrt_n_reg;
    logic               cor_start_reg;
    cordic_mode_t       cor_mode_reg;
    logic signed [63:0] cor_x_reg;
    logic signed [63:0] cor_y_reg;
    logic signed [63:0] cor_z_reg;

    logic               mul_done;
    logic [127:0]       mul_product;
    logic               div_done;
    logic [127:0]       div_quot;
    logic               sqrt_done;
    logic [63:0]        sqrt_root;
    logic               cor_done;
    logic signed [63:0] cor_x;
    logic signed [63:0] cor_y;
    logic signed [63:0] cor_z;

    logic [48:0]        e2c;
    logic [63:0]        q48;
    logic [63:0]        rnd62;
    logic [63:0]        w_val;
    logic [63:0]        mag_c;
    logic signed [63:0] term_val;

    e2g_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    e2g_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_n_reg),
        .divisor  (div_d_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    e2g_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start_reg),
        .radicand (sqrt_n_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    e2g_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start_reg),
        .mode    (cor_mode_reg),
        .x_in    (cor_x_reg),
        .y_in    (cor_y_reg),
        .z_in    (cor_z_reg),
        .done    (cor_done),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z)
    );

    always_comb begin
        e2c      = 49'h1_0000_0000_0000 - {1'b0, e2_reg};
        q48      = mul_product[111:48];
        rnd62    = cap_lmax((mul_product + (128'd1 << 61)) >> 62);
        w_val    = (q48 >= ONE_Q62) ? 64'd1 : ONE_Q62 - q48;
        mag_c    = mag64(c_reg);
        term_val = with_sign(rnd62, s_reg[63]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            a_reg          <= A_RESET;
            e2_reg         <= E2_RESET;
            m_valid_reg    <= 1'b0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            cor_start_reg  <= 1'b0;
        end else begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            cor_start_reg  <= 1'b0;
            // the output state reloads the register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SEMI_MAJOR: a_reg  <= cfg_data[35:0];
                    REG_ECC_SQ:     e2_reg <= cfg_data[47:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg         <= 64'(s_data.ecef_x) <<< FRAC;
                        y_reg         <= 64'(s_data.ecef_y) <<< FRAC;
                        z_reg         <= 64'(s_data.ecef_z) <<< FRAC;
                        mul_a_reg     <= mag64(64'(s_data.ecef_x) <<< FRAC);
                        mul_b_reg     <= mag64(64'(s_data.ecef_x) <<< FRAC);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SQ_X;
                    end
                end
                ST_SQ_X: begin
                    if (mul_done) begin
                        acc_reg       <= mul_product;
                        mul_a_reg     <= mag64(y_reg);
                        mul_b_reg     <= mag64(y_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SQ_Y;
                    end
                end
                ST_SQ_Y: begin
                    if (mul_done) begin
                        sqrt_n_reg     <= acc_reg + mul_product;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT_P;
                    end
                end
                ST_ROOT_P: begin
                    if (sqrt_done) begin
                        p_reg         <= sqrt_root;
                        cor_mode_reg  <= CORDIC_VEC;
                        cor_x_reg     <= x_reg;
                        cor_y_reg     <= y_reg;
                        cor_z_reg     <= 64'sd0;
                        cor_start_reg <= 1'b1;
                        state_reg     <= ST_LON;
                    end
                end
                ST_LON: begin
                    if (cor_done) begin
                        lon_reg       <= cor_z;
                        mul_a_reg     <= p_reg;
                        mul_b_reg     <= {15'b0, e2c};
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PP;
                    end
                end
                ST_PP: begin
                    if (mul_done) begin
                        cor_mode_reg  <= CORDIC_VEC;
                        cor_x_reg     <= $signed(q48);
                        cor_y_reg     <= z_reg;
                        cor_start_reg <= 1'b1;
                        state_reg     <= ST_LAT0;
                    end
                end
                ST_LAT0, ST_LATK: begin
                    if (cor_done) begin
                        lat_reg       <= cor_z;
                        k_reg         <= (state_reg == ST_LATK) ? k_reg + 1'b1 : '0;
                        cor_mode_reg  <= CORDIC_ROT;
                        cor_z_reg     <= cor_z;
                        cor_start_reg <= 1'b1;
                        state_reg     <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (cor_done) begin
                        c_reg         <= cor_x;
                        s_reg         <= cor_y;
                        mul_a_reg     <= mag64(cor_y);
                        mul_b_reg     <= mag64(cor_y);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_SIN2;
                    end
                end
                ST_SIN2: begin
                    if (mul_done) begin
                        mul_a_reg     <= {16'b0, e2_reg};
                        mul_b_reg     <= rnd62;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_E2S2;
                    end
                end
                ST_E2S2: begin
                    if (mul_done) begin
                        sqrt_n_reg     <= {64'b0, w_val} << 62;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT_W;
                    end
                end
                ST_ROOT_W: begin
                    if (sqrt_done) begin
                        div_n_reg     <= {92'b0, a_reg} << (62 + FRAC);
                        div_d_reg     <= sqrt_root;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_NPV;
                    end
                end
                ST_NPV: begin
                    if (div_done) begin
                        n_reg <= cap_lmax(div_quot);
                        if (k_reg < K_W'(REFINE_STEPS)) begin
                            mul_a_reg     <= {16'b0, e2_reg};
                            mul_b_reg     <= cap_lmax(div_quot);
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_T1;
                        end else if (mag_c > COS_FLOOR) begin
                            div_n_reg     <= {64'b0, p_reg} << 62;
                            div_d_reg     <= mag_c;
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_HDIV;
                        end else begin
                            // near a pole: height from the polar radius
                            sqrt_n_reg     <= {79'b0, e2c} << 76;
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= ST_ROOT_B;
                        end
                    end
                end
                ST_T1: begin
                    if (mul_done) begin
                        mul_a_reg     <= cap_lmax(mul_product >> 48);
                        mul_b_reg     <= mag64(s_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TERM;
                    end
                end
                ST_TERM: begin
                    if (mul_done) begin
                        cor_mode_reg  <= CORDIC_VEC;
                        cor_x_reg     <= $signed(p_reg);
                        cor_y_reg     <= sat_add(z_reg, term_val);
                        cor_start_reg <= 1'b1;
                        state_reg     <= ST_LATK;
                    end
                end
                ST_HDIV: begin
                    if (div_done) begin
                        h_reg     <= sat_add(with_sign(cap_lmax(div_quot), c_reg[63]),
                                             -$signed(n_reg));
                        state_reg <= ST_OUT;
                    end
                end
                ST_ROOT_B: begin
                    if (sqrt_done) begin
                        mul_a_reg     <= {28'b0, a_reg};
                        mul_b_reg     <= sqrt_root;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_POLAR;
                    end
                end
                ST_POLAR: begin
                    if (mul_done) begin
                        h_reg     <= sat_add($signed(mag64(z_reg)),
                                             -$signed(cap_lmax(mul_product >> (62 - FRAC))));
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.longitude <= angle_out(lon_reg);
                        m_data_reg.latitude  <= angle_out(lat_reg);
                        m_data_reg.height_mm <= length_out(h_reg);
                        m_valid_reg          <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_done_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(mul_done || div_done || sqrt_done || cor_done))
        else $error("arithmetic unit finished while sequencer idle");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_refine_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_W'(REFINE_STEPS))
        else $error("refinement count overrun");

endmodule
